[hw/rtl/sfe_pkg.sv]
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants, types and helpers of the stereo feedback echo core.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  // delay store geometry (depth is a power of two, addresses wrap)
  localparam int DELAY_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  // sample and coefficient widths
  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 16;
  localparam int FB_W     = 16;
  localparam int WIDTH_W  = 15;
  localparam int ACC_W    = 36;

  // unity feedback in Q1.15
  localparam logic [FB_W-1:0] FB_UNITY = FB_W'(32768);

  // right tap offset: floor(delay * width / (5 * 2^16))
  localparam int PROD_W    = DELAY_W + WIDTH_W;
  localparam int OFF_SHIFT = 16;
  localparam int QUOT_W    = PROD_W - OFF_SHIFT;
  localparam int RECIP_W   = 16;
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(52429);
  localparam int RECIP_SHIFT = 18;

  // reset values of the registers
  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(13230);
  localparam logic [FB_W-1:0]    FB_RST    = FB_W'(13107);
  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(16384);

  // saturation bounds
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // settle time of the offset pipeline after a register write
  localparam logic [1:0] CFG_SETTLE = 2'd2;

  // register indexes
  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WIDTH    = 2'd2
  } cfg_reg_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [FB_W-1:0]    fb;
    logic [ADDR_W-1:0]  off;
    logic               busy;
  } cfg_t;

  // per-item control shared by both lanes
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              fill_wrap;
  } lane_ctl_t;

  // result clamped to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[SAMPLE_W-1:0];
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sfe_cfg.sv]
// ----------------------------------------------------------------------------
// sfe_cfg
// Register bank with feedback clamp and a two-stage right tap offset unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [1:0]                   wr_index,
  input  wire logic [sfe_pkg::FB_W-1:0]     wr_data,
  output sfe_pkg::cfg_t                     cfg
);

  logic [sfe_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic [sfe_pkg::FB_W-1:0]    fb_r, fb_nxt;
  logic [sfe_pkg::WIDTH_W-1:0] width_r, width_nxt;
  logic [sfe_pkg::PROD_W-1:0]  prod_r;
  logic [sfe_pkg::ADDR_W-1:0]  off_r;
  logic [1:0]                  pend_r, pend_nxt;

  logic [sfe_pkg::QUOT_W-1:0]  quot;
  logic [sfe_pkg::QUOT_W+sfe_pkg::RECIP_W-1:0] recip_prod;

  // register writes
  always_comb begin
    delay_nxt = delay_r;
    fb_nxt    = fb_r;
    width_nxt = width_r;
    if (wr_en) begin
      unique case (wr_index)
        sfe_pkg::REG_DELAY:    delay_nxt = wr_data[sfe_pkg::DELAY_W-1:0];
        sfe_pkg::REG_FEEDBACK: fb_nxt    = wr_data[sfe_pkg::FB_W-1:0];
        sfe_pkg::REG_WIDTH:    width_nxt = wr_data[sfe_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // settle counter, busy while the offset recomputes after a write
  always_comb begin
    if (wr_en) begin
      pend_nxt = sfe_pkg::CFG_SETTLE;
    end else if (pend_r != 2'd0) begin
      pend_nxt = pend_r - 2'd1;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= sfe_pkg::DELAY_RST;
      fb_r    <= sfe_pkg::FB_RST;
      width_r <= sfe_pkg::WIDTH_RST;
      pend_r  <= sfe_pkg::CFG_SETTLE;
    end else begin
      delay_r <= delay_nxt;
      fb_r    <= fb_nxt;
      width_r <= width_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // offset: product, then divide by 5 * 2^16 via shift and reciprocal
  assign quot       = prod_r[sfe_pkg::PROD_W-1:sfe_pkg::OFF_SHIFT];
  assign recip_prod = (sfe_pkg::QUOT_W+sfe_pkg::RECIP_W)'(quot) *
                      (sfe_pkg::QUOT_W+sfe_pkg::RECIP_W)'(sfe_pkg::RECIP_5);

  always_ff @(posedge clk) begin
    prod_r <= sfe_pkg::PROD_W'(delay_r) * sfe_pkg::PROD_W'(width_r);
    off_r  <= sfe_pkg::ADDR_W'(recip_prod >> sfe_pkg::RECIP_SHIFT);
  end

  // clamp feedback above unity
  always_comb begin
    cfg.delay = delay_r;
    cfg.fb    = (fb_r > sfe_pkg::FB_UNITY) ? sfe_pkg::FB_UNITY : fb_r;
    cfg.off   = off_r;
    cfg.busy  = (pend_r != 2'd0);
  end

endmodule

`default_nettype wire

[hw/rtl/sfe_lane.sv]
// ----------------------------------------------------------------------------
// sfe_lane
// One channel: delay store, tap read with write forwarding, feedback math.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_lane (
  input  wire logic                                clk,
  input  wire sfe_pkg::lane_ctl_t                  ctl,
  input  wire logic [sfe_pkg::ADDR_W-1:0]          rd_addr,
  input  wire logic signed [sfe_pkg::SAMPLE_W-1:0] x_in,
  input  wire logic [sfe_pkg::FB_W-1:0]            fb,
  output logic signed [sfe_pkg::SAMPLE_W-1:0]      y_out
);

  logic [sfe_pkg::SAMPLE_W-1:0] mem [sfe_pkg::DELAY_DEPTH];

  logic [sfe_pkg::SAMPLE_W-1:0]        rdata_r;
  logic                                rvalid_r;
  logic                                hit_r;
  logic signed [sfe_pkg::SAMPLE_W-1:0] x_r;
  logic signed [sfe_pkg::SAMPLE_W-1:0] lastw_r;

  logic                                rvalid;
  logic signed [sfe_pkg::SAMPLE_W-1:0] tap;
  logic signed [sfe_pkg::FB_W:0]       fb_s;
  logic signed [sfe_pkg::SAMPLE_W+sfe_pkg::FB_W:0] p_d, p_x;
  logic signed [sfe_pkg::ACC_W-1:0]    st_sum, out_sum;
  logic signed [sfe_pkg::SAMPLE_W-1:0] st_val;

  // entries below the write pointer were written, all are after a wrap
  assign rvalid = ctl.fill_wrap || (rd_addr < ctl.wr_addr);

  // delay store, read-before-write
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= st_val;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // item capture, forward the write that lands on the same edge
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rvalid_r <= rvalid;
      hit_r    <= ctl.wr_en && (rd_addr == ctl.wr_addr);
      x_r      <= x_in;
    end
    if (ctl.wr_en) begin
      lastw_r <= st_val;
    end
  end

  // delayed sample
  always_comb begin
    if (hit_r) begin
      tap = lastw_r;
    end else if (rvalid_r) begin
      tap = signed'(rdata_r);
    end else begin
      tap = '0;
    end
  end

  // feedback products
  assign fb_s = signed'({1'b0, fb});
  assign p_d  = tap * fb_s;
  assign p_x  = x_r * fb_s;

  // store: (x*2^15 + d*fb) / 2^15, output: (2*d*(1-fb) + x*fb) / 2^16
  assign st_sum  = (sfe_pkg::ACC_W'(x_r) <<< 15) + sfe_pkg::ACC_W'(p_d)
                 + sfe_pkg::ACC_W'(16384);
  assign out_sum = (sfe_pkg::ACC_W'(tap) <<< 16) - (sfe_pkg::ACC_W'(p_d) <<< 1)
                 + sfe_pkg::ACC_W'(p_x) + sfe_pkg::ACC_W'(32768);

  assign st_val = sfe_pkg::sat_sample(st_sum >>> 15);
  assign y_out  = sfe_pkg::sat_sample(out_sum >>> 16);

endmodule

`default_nettype wire

[hw/rtl/stereo_feedback_echo_core.sv]
// ----------------------------------------------------------------------------
// stereo_feedback_echo_core
// Stereo feedback echo: two delay lanes sharing one write pointer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stereo sample pair per item, left in tdata[15:0], right in
//           tdata[31:16], both signed Q1.15.
//   out_* : one echoed pair per input item, same packing, in input order.
//   cfg_* : register writes (0 delay, 1 feedback, 2 stereo width), always
//           taken; write only while no item is in flight.
// Throughput is one item per clock unless the receiver or a register write
// stalls it. Each lane writes the store value from its registered tap, so
// the feedback loop of one multiply, add, round and clamp sets the cycle; a
// one-sample delay is forwarded. Items pass the lane register, then the
// output register. After reset, and after any register write, in_tready
// stays low while the right tap offset (two multiplier stages) settles.
// Stores read as zero until written; a fill pointer tracks this, so no
// clearing pass is needed. A stalled receiver holds the output register;
// one more item is taken into the lanes, then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_echo_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_left [15:0], in_right [31:16]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  // out_left [15:0], out_right [31:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  sfe_pkg::cfg_t      cfg;
  sfe_pkg::lane_ctl_t ctl;

  logic                                in_acc, s1_adv;
  logic                                v1_r, v1_nxt;
  logic [sfe_pkg::ADDR_W-1:0]          widx_r, widx_nxt;
  logic [sfe_pkg::ADDR_W-1:0]          wptr_r, wptr_nxt;
  logic                                wrap_r, wrap_nxt;
  logic [sfe_pkg::ADDR_W-1:0]          ra_left, ra_right;
  logic signed [sfe_pkg::SAMPLE_W-1:0] y_left, y_right;
  logic                                out_valid_r, out_valid_nxt;
  logic [2*sfe_pkg::SAMPLE_W-1:0]      out_data_r;

  // configuration
  assign cfg_ready = 1'b1;

  sfe_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake and stage advance
  assign s1_adv    = v1_r && (!out_valid_r || out_tready);
  assign in_tready = !cfg.busy && (!v1_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  // tap addresses
  assign ra_left  = widx_r - sfe_pkg::ADDR_W'(cfg.delay);
  assign ra_right = ra_left + cfg.off;

  always_comb begin
    ctl.rd_en     = in_acc;
    ctl.wr_en     = s1_adv;
    ctl.wr_addr   = wptr_r;
    ctl.fill_wrap = wrap_r;
  end

  // pointers and lane occupancy
  always_comb begin
    widx_nxt = in_acc ? widx_r + sfe_pkg::ADDR_W'(1) : widx_r;
    wptr_nxt = s1_adv ? wptr_r + sfe_pkg::ADDR_W'(1) : wptr_r;
    wrap_nxt = wrap_r || (s1_adv && (wptr_r == {sfe_pkg::ADDR_W{1'b1}}));
    if (in_acc) begin
      v1_nxt = 1'b1;
    end else if (s1_adv) begin
      v1_nxt = 1'b0;
    end else begin
      v1_nxt = v1_r;
    end
  end

  // output register
  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      widx_r      <= '0;
      wptr_r      <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      widx_r      <= widx_nxt;
      wptr_r      <= wptr_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // merge the two lane results into one item
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {y_right, y_left};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // lanes
  sfe_lane u_lane_l (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (ra_left),
    .x_in    (signed'(in_tdata[sfe_pkg::SAMPLE_W-1:0])),
    .fb      (cfg.fb),
    .y_out   (y_left)
  );

  sfe_lane u_lane_r (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (ra_right),
    .x_in    (signed'(in_tdata[2*sfe_pkg::SAMPLE_W-1:sfe_pkg::SAMPLE_W])),
    .fb      (cfg.fb),
    .y_out   (y_right)
  );

`ifndef SYNTHESIS
  // accept pointer leads the write pointer by the item in the lanes
  assert property (@(posedge clk) disable iff (!rst_n)
    widx_r == wptr_r + sfe_pkg::ADDR_W'(v1_r))
    else $error("accept and write pointers out of step");

  // a lane item always lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("lane item lost");

  // no item taken while the offset settles
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_tready)
    else $error("item accepted during offset settle");

  // fill wrap never clears outside reset
  assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(wrap_r))
    else $error("fill wrap flag cleared");
`endif

endmodule

`default_nettype wire
